>>> rtl/kld_pkg.sv
// ----------------------------------------------------------------------------
// kld_pkg: shared types, constants and log table for the KL divergence block
// Fixed-point widths, queue entry type and the elaborated log2 mantissa table.
// ----------------------------------------------------------------------------
package kld_pkg;

  localparam int ProbW        = 18;               // signed Q.16 probability
  localparam int MagW         = 17;               // magnitude bits fed to log2
  localparam int LogTableBits = 8;
  localparam int TabSize      = 1 << LogTableBits;
  localparam int TabW         = 17;               // table entries up to 65536
  localparam int ExpW         = 5;                // leading-one position 0..16
  localparam int LogW         = 21;               // e*65536 + T[m]
  localparam int DiffW        = LogW + 1;         // signed log difference
  localparam int LnW          = 22;               // signed ln in Q.16
  localparam int TermW        = 24;               // signed term in Q.16
  localparam int SumW         = 41;
  localparam int Ln2Q16       = 45426;
  localparam int FifoDepth    = 4;
  localparam int FrontStages  = 3;

  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_SKIP,
    OP_TERM,
    OP_POISON
  } kld_op_e;

  typedef struct packed {
    kld_op_e                  op;
    logic                     last;
    logic signed [TermW-1:0]  term;
  } kld_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } kld_fifo_status_t;

  typedef logic [TabW-1:0] log_tab_t [TabSize];

  // round(65536*log2(1 + m/TabSize)) by repeated squaring in Q1.63
  function automatic logic [TabW-1:0] log_entry(input int unsigned m);
    logic [63:0]  x;
    logic [127:0] prod;
    logic [17:0]  bits;
    x    = {1'b1, 63'd0} | (64'(m) << (63 - LogTableBits));
    bits = '0;
    for (int k = 0; k < 17; k++) begin
      prod = {64'd0, x} * {64'd0, x};
      bits = {bits[16:0], 1'b0};
      if (prod[127]) begin
        bits[0] = 1'b1;
        x       = prod[127:64];
      end else begin
        x = {prod[126:64], prod[63]};
      end
    end
    log_entry = TabW'((bits + 18'd1) >> 1);
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t t;
    for (int m = 0; m < TabSize; m++) begin
      t[m] = log_entry(m);
    end
    return t;
  endfunction

  localparam log_tab_t LogTab = build_log_tab();

  // log2 of a 17-bit magnitude in Q.16
  function automatic logic [LogW-1:0] log2_q16(input logic [MagW-1:0] x);
    logic [ExpW-1:0]         e;
    logic [MagW-1:0]         xn;
    logic [LogTableBits-1:0] m;
    e = '0;
    for (int i = 1; i < MagW; i++) begin
      if (x[i]) e = ExpW'(i);
    end
    xn = x << (ExpW'(MagW - 1) - e);
    m  = xn[MagW-2 -: LogTableBits];
    log2_q16 = {e, 16'd0} + LogW'(LogTab[m]);
  endfunction

endpackage

>>> rtl/kld_front.sv
// ----------------------------------------------------------------------------
// kld_front: item intake and term pipeline
// Classifies each item and computes P*ln(P/Q) over three register stages.
// ----------------------------------------------------------------------------
module kld_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [kld_pkg::ProbW-1:0] p_prob_i,
  input  logic signed [kld_pkg::ProbW-1:0] q_prob_i,
  input  logic                          row_last_i,
  input  kld_pkg::kld_fifo_status_t     fifo_status_i,
  output logic                          push_o,
  output kld_pkg::kld_entry_t           push_entry_o
);
  import kld_pkg::*;

  localparam int Prod1W = DiffW + 17;
  localparam int Prod2W = ProbW + LnW;
  localparam logic signed [16:0] Ln2Const = 17'(Ln2Q16);

  logic                    en;
  logic                    s0_v_q, s1_v_q, s2_v_q;
  logic signed [ProbW-1:0] s0_p_q, s0_q_q, s1_p_q, s2_p_q;
  logic                    s0_last_q, s1_last_q, s2_last_q;
  kld_op_e                 s0_op_d, s1_op_q, s2_op_q;
  logic signed [DiffW-1:0] s1_d_d, s1_d_q;
  logic signed [LnW-1:0]   s2_ln_d, s2_ln_q;
  logic signed [Prod1W-1:0] prod1;
  logic signed [Prod2W-1:0] prod2;
  logic [LogW-1:0]         lp, lq;

  // hold the whole pipe only when the tail cannot hand off
  assign en         = !(s2_v_q && fifo_status_i.full);
  assign in_stall_o = !en;

  always_comb begin
    if (s0_p_q > 0 && s0_q_q > 0) begin
      s0_op_d = OP_TERM;
    end else if (s0_p_q < 0) begin
      s0_op_d = OP_POISON;
    end else begin
      s0_op_d = OP_SKIP;
    end
  end

  assign lp     = log2_q16(s0_p_q[MagW-1:0]);
  assign lq     = log2_q16(s0_q_q[MagW-1:0]);
  assign s1_d_d = $signed({1'b0, lp}) - $signed({1'b0, lq});

  assign prod1   = s1_d_q * Ln2Const;
  assign s2_ln_d = LnW'(prod1 >>> 16);

  assign prod2 = s2_p_q * s2_ln_q;

  assign push_o             = s2_v_q && !fifo_status_i.full;
  assign push_entry_o.op    = s2_op_q;
  assign push_entry_o.last  = s2_last_q;
  assign push_entry_o.term  = $signed(prod2[Prod2W-1:16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
      s1_v_q <= s0_v_q;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_p_q    <= p_prob_i;
      s0_q_q    <= q_prob_i;
      s0_last_q <= row_last_i;
      s1_p_q    <= s0_p_q;
      s1_last_q <= s0_last_q;
      s1_op_q   <= s0_op_d;
      s1_d_q    <= s1_d_d;
      s2_p_q    <= s1_p_q;
      s2_last_q <= s1_last_q;
      s2_op_q   <= s1_op_q;
      s2_ln_q   <= s2_ln_d;
    end
  end

endmodule

>>> rtl/kld_fifo.sv
// ----------------------------------------------------------------------------
// kld_fifo: short queue between term pipeline and accumulator
// Power-of-two depth, registered entries, first-word read-through.
// ----------------------------------------------------------------------------
module kld_fifo #(
  parameter int Depth = kld_pkg::FifoDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  kld_pkg::kld_entry_t       push_entry_i,
  input  logic                      pop_i,
  output kld_pkg::kld_entry_t       pop_entry_o,
  output kld_pkg::kld_fifo_status_t status_o
);
  import kld_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  kld_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign pop_entry_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

>>> rtl/kld_back.sv
// ----------------------------------------------------------------------------
// kld_back: row accumulator and result register
// Applies queued terms with saturation, poisons rows, emits row results.
// ----------------------------------------------------------------------------
module kld_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           sentinel_we_i,
  input  logic signed [kld_pkg::SumW-1:0] sentinel_i,
  input  kld_pkg::kld_fifo_status_t      fifo_status_i,
  input  kld_pkg::kld_entry_t            pop_entry_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [kld_pkg::SumW-1:0] divergence_o
);
  import kld_pkg::*;

  logic signed [SumW-1:0] sentinel_q;
  logic signed [SumW-1:0] sum_q, sum_d, row_res;
  logic                   poisoned_q, poisoned_d, poison_now;
  logic signed [SumW:0]   sum_ext;
  logic signed [SumW-1:0] sum_sat;
  logic                   out_valid_q;
  logic signed [SumW-1:0] divergence_q;

  // advance when the result slot is free or being taken
  assign pop_o = !fifo_status_i.empty && (!out_valid_q || !out_stall_i);

  assign sum_ext = {sum_q[SumW-1], sum_q}
                 + (SumW+1)'(pop_entry_i.term);

  always_comb begin
    if (sum_ext[SumW] != sum_ext[SumW-1]) begin
      sum_sat = sum_ext[SumW] ? SumMin : SumMax;
    end else begin
      sum_sat = sum_ext[SumW-1:0];
    end
  end

  always_comb begin
    row_res    = sum_q;
    poison_now = poisoned_q;
    if (!poisoned_q) begin
      case (pop_entry_i.op)
        OP_TERM: row_res = sum_sat;
        OP_POISON: begin
          row_res    = sentinel_q;
          poison_now = 1'b1;
        end
        default: row_res = sum_q;
      endcase
    end
    if (pop_entry_i.last) begin
      sum_d      = '0;
      poisoned_d = 1'b0;
    end else begin
      sum_d      = row_res;
      poisoned_d = poison_now;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign divergence_o = divergence_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sentinel_q  <= SumMax;
      sum_q       <= '0;
      poisoned_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sentinel_we_i) sentinel_q <= sentinel_i;
      if (pop_o) begin
        sum_q      <= sum_d;
        poisoned_q <= poisoned_d;
      end
      if (pop_o && pop_entry_i.last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && pop_entry_i.last) divergence_q <= row_res;
  end

endmodule

>>> rtl/kl_divergence_accumulator.sv
// ----------------------------------------------------------------------------
// kl_divergence_accumulator: streaming KL divergence row sum
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o    p_prob_i, q_prob_i, row_last_i
//   out      output     out_valid_o / out_stall_i  divergence_o
//   cfg      input      negative_sentinel_we_i     negative_sentinel_i
//
// Sustains one item per cycle while in_stall_o is low. A row result passes
// through two more term stages, the queue write, then the result register
// after its last item transfers.
// The running sum is one 41-bit saturating add; it and the poison flag are the only loops across items.
// Reset clears the pipe, queue, sum and poison flag; sentinel returns to max.
// A stalled output holds the accumulator, the queue then fills and the input
// stalls; a stall on the input side never blocks a waiting result.
// ----------------------------------------------------------------------------
module kl_divergence_accumulator #(
  parameter int FifoDepth = kld_pkg::FifoDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            negative_sentinel_we_i,
  input  logic signed [kld_pkg::SumW-1:0]  negative_sentinel_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [kld_pkg::ProbW-1:0] p_prob_i,
  input  logic signed [kld_pkg::ProbW-1:0] q_prob_i,
  input  logic                            row_last_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [kld_pkg::SumW-1:0]  divergence_o
);
  import kld_pkg::*;

  kld_fifo_status_t fifo_status;
  logic             push, pop;
  kld_entry_t       push_entry, pop_entry;

  kld_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .p_prob_i     (p_prob_i),
    .q_prob_i     (q_prob_i),
    .row_last_i   (row_last_i),
    .fifo_status_i(fifo_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  kld_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .pop_i       (pop),
    .pop_entry_o (pop_entry),
    .status_o    (fifo_status)
  );

  kld_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sentinel_we_i(negative_sentinel_we_i),
    .sentinel_i   (negative_sentinel_i),
    .fifo_status_i(fifo_status),
    .pop_entry_i  (pop_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .divergence_o (divergence_o)
  );

endmodule

>>> rtl/kld_checker.sv
// ----------------------------------------------------------------------------
// kld_checker: port-level checks for the KL divergence block
// Tracks row results owed from accepted last items and checks the output.
// ----------------------------------------------------------------------------
module kld_checker #(
  parameter int FifoDepth = kld_pkg::FifoDepth
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            row_last_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [kld_pkg::SumW-1:0]  divergence_o
);
  import kld_pkg::*;

  localparam int Capacity = FrontStages + FifoDepth + 1;
  localparam int CntW     = $clog2(Capacity + 2);

  logic            in_last_xfer, out_xfer;
  logic [CntW-1:0] owed_q;

  assign in_last_xfer = in_valid_i && !in_stall_o && row_last_i;
  assign out_xfer     = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= '0;
    end else begin
      case ({in_last_xfer, out_xfer})
        2'b10:   owed_q <= owed_q + 1'b1;
        2'b01:   owed_q <= owed_q - 1'b1;
        default: owed_q <= owed_q;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(divergence_o))
    else $error("stalled result changed or dropped");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> owed_q != '0)
    else $error("result shown without an accepted last item");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    owed_q <= CntW'(Capacity))
    else $error("more rows in flight than the block can hold");

endmodule

bind kl_divergence_accumulator kld_checker #(
  .FifoDepth(FifoDepth)
) u_kld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .row_last_i  (row_last_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .divergence_o(divergence_o)
);
